// ----- rtl/crcls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_pkg
// Shared constants and register codes for the length-seeded CRC block.
// ----------------------------------------------------------------------------
package crcls_pkg;

   localparam int CRC_WIDTH = 24;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 24;
   localparam int POLY_W    = CRC_WIDTH;
   localparam int RESULT_W  = CRC_WIDTH;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;
   localparam int REQ_DW    = BYTE_W + LEN_W;
   localparam int RSP_DW    = CRC_WIDTH;

   localparam logic [POLY_W-1:0] POLY_RESET = 24'h864CFB;

   typedef enum logic {
      REG_POLYNOMIAL = 1'b0,
      REG_UNUSED     = 1'b1
   } reg_index_type;

endpackage : crcls_pkg
`default_nettype wire

// ----- rtl/crcls_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_csr
// Register port: holds the generator polynomial, serves reads and writes.
// ----------------------------------------------------------------------------
module crcls_csr
   import crcls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output logic      [POLY_W-1:0] polynomial
);

   logic [POLY_W-1:0] poly_ff;
   logic [POLY_W-1:0] poly_in;
   reg_index_type     reg_index;
   logic              wr_en;

   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign polynomial = poly_ff;

   always_comb begin
      poly_in = poly_ff;
      if (wr_en && (reg_index == REG_POLYNOMIAL) && (csr_paddr[1:0] == 2'b00)) begin
         poly_in = csr_pwdata[POLY_W-1:0];
      end
   end

   always_comb begin
      case (reg_index)
         REG_POLYNOMIAL: csr_prdata = {{(CSR_DW-POLY_W){1'b0}}, poly_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

endmodule : crcls_csr
`default_nettype wire

// ----- rtl/crcls_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_update
// One byte of CRC update: optional seed, then eight bitwise division steps.
// ----------------------------------------------------------------------------
module crcls_update
   import crcls_pkg::*;
(
   input  wire logic [CRC_WIDTH-1:0] acc,
   input  wire logic [POLY_W-1:0]    polynomial,
   input  wire logic [BYTE_W-1:0]    data_byte,
   input  wire logic                 first_byte,
   input  wire logic [LEN_W-1:0]     message_length,
   output logic      [CRC_WIDTH-1:0] acc_next
);

   localparam int SHIFT = CRC_WIDTH - BYTE_W;

   logic [CRC_WIDTH-1:0] poly;
   logic [LEN_W:0]       seed_sum;
   logic [CRC_WIDTH-1:0] seed;
   logic [BYTE_W-1:0]    idx;

   assign poly     = CRC_WIDTH'(polynomial);
   assign seed_sum = {1'b0, message_length} + {{(LEN_W+1-BYTE_W){1'b0}}, data_byte};

   always_comb begin
      seed = first_byte ? CRC_WIDTH'(seed_sum) : acc;
      idx  = seed[CRC_WIDTH-1 -: BYTE_W] ^ data_byte;
   end

   // table entry for idx, worked out bit by bit
   always_comb begin
      logic [CRC_WIDTH-1:0] rem;
      logic [CRC_WIDTH-1:0] dat;
      rem = '0;
      dat = {idx, {SHIFT{1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (dat[CRC_WIDTH-1] ^ rem[CRC_WIDTH-1]) begin
            rem = {rem[CRC_WIDTH-2:0], 1'b0} ^ poly;
         end else begin
            rem = {rem[CRC_WIDTH-2:0], 1'b0};
         end
         dat = {dat[CRC_WIDTH-2:0], 1'b0};
      end
      acc_next = {seed[SHIFT-1:0], {BYTE_W{1'b0}}} ^ rem;
   end

endmodule : crcls_update
`default_nettype wire

// ----- rtl/crc24_length_seeded_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc24_length_seeded_top
// Length-seeded MSB-first CRC over a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  req_     | in        | tdata = data_byte[7:0], message_length[31:8];
//           |           | tuser = first_byte; tlast = last_byte
//  rsp_     | out       | tdata = crc_value[23:0], one per byte marked last
//  csr_     | in/out    | APB register port, polynomial at address 0
//
//  One byte per cycle unless a waiting result stalls; result valid the cycle after the last byte leaves s1.
//  The byte update is one pass of XOR logic between the input stage and
//  the accumulator; the result register holds the CRC until taken.
//  Synchronous reset clears valids and the accumulator and sets the polynomial to POLY_RESET.
//  A waiting result holds a byte marked last in the input stage and stalls
//  the input behind it.
// ----------------------------------------------------------------------------
module crc24_length_seeded_top
   import crcls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,   // data_byte, message_length
   input  wire logic              req_tuser,   // first_byte
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [RSP_DW-1:0] rsp_tdata,   // crc_value
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   logic [POLY_W-1:0]    polynomial;

   logic                 s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]    s1_byte_ff;
   logic [LEN_W-1:0]     s1_len_ff;
   logic                 s1_first_ff;
   logic                 s1_last_ff;
   logic                 s1_fire;
   logic                 req_fire;

   logic [CRC_WIDTH-1:0] acc_ff, acc_in, acc_next;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]    rsp_data_ff, rsp_data_in;

   crcls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .polynomial  (polynomial)
   );

   crcls_update u_update (
      .acc            (acc_ff),
      .polynomial     (polynomial),
      .data_byte      (s1_byte_ff),
      .first_byte     (s1_first_ff),
      .message_length (s1_len_ff),
      .acc_next       (acc_next)
   );

   // advance the input stage unless it carries a last byte and the result is stuck
   assign s1_fire    = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_fire;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s1_valid_in  = req_fire | (s1_valid_ff & ~s1_fire);
      acc_in       = s1_fire ? acc_next : acc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DW'(acc_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_tdata[BYTE_W-1:0];
         s1_len_ff   <= req_tdata[BYTE_W +: LEN_W];
         s1_first_ff <= req_tuser;
         s1_last_ff  <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> rsp_valid_ff)
      else $error("last byte did not load a result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(acc_ff))
      else $error("accumulator moved without a byte");

endmodule : crc24_length_seeded_top
`default_nettype wire
